// File: rtl/core/rba_pkg.sv
// Shared constants, codes and control structs for the region bump allocator.
// Used by rba_slots, rba_bump and the top level region_bump_allocator_with_slots.
package rba_pkg;

	localparam int EP_SLOTS    = 64;
	localparam int NT_SLOTS    = 64;
	localparam int ALIGN_BYTES = 64;   // must be a power of two

	localparam int EP_IDX_W = (EP_SLOTS > 1) ? $clog2(EP_SLOTS) : 1;
	localparam int NT_IDX_W = (NT_SLOTS > 1) ? $clog2(NT_SLOTS) : 1;

	localparam int SIZE_W   = 32;
	localparam int OBJ_W    = 20;
	localparam int SLOT_W   = 6;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W = 3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_SLOT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

	// request codes
	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_DESTROY = 1'b1;

	localparam logic [1:0] OBJ_CNODE = 2'd0;
	localparam logic [1:0] OBJ_EP    = 2'd1;
	localparam logic [1:0] OBJ_NT    = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_SIZE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CNODE_SIZE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EP_SIZE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NT_SIZE     = 3'd4;

	// slot table updates, applied at the commit edge
	typedef struct packed {
		logic claim_ep;
		logic claim_nt;
		logic owner;
		logic release_ep;
		logic release_nt;
	} rba_slot_cmd_t;

	// slot table lookups for the beat in the input register
	typedef struct packed {
		logic                ep_free_ok;
		logic [EP_IDX_W-1:0] ep_free_idx;
		logic                nt_free_ok;
		logic [NT_IDX_W-1:0] nt_free_idx;
		logic                ep_used;
		logic                ep_owner;
		logic                nt_used;
		logic                nt_owner;
	} rba_slot_info_t;

	// region updates, applied at the commit edge
	typedef struct packed {
		logic alloc;
		logic release_obj;
		logic owner;
	} rba_bump_upd_t;

	typedef struct packed {
		logic [SIZE_W-1:0] watermark;
		logic [SIZE_W-1:0] free_bytes;
		logic [SIZE_W-1:0] objects;
	} rba_stats_t;

endpackage

// File: rtl/core/rba_slots.sv
// Endpoint and notification slot tables: used bitmaps, owner bits and
// lowest-free priority encoders. Depends on rba_pkg.
module rba_slots
	import rba_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           commit,
	input  rba_slot_cmd_t  cmd,
	input  logic [SLOT_W-1:0] slot,
	output rba_slot_info_t info
);

	logic [EP_SLOTS-1:0] ep_used_q;
	logic [EP_SLOTS-1:0] ep_owner_q;
	logic [NT_SLOTS-1:0] nt_used_q;
	logic [NT_SLOTS-1:0] nt_owner_q;

	logic [EP_IDX_W-1:0] ep_sel;
	logic [NT_IDX_W-1:0] nt_sel;
	logic                ep_in_range;
	logic                nt_in_range;

	assign ep_sel      = EP_IDX_W'(slot);
	assign nt_sel      = NT_IDX_W'(slot);
	assign ep_in_range = int'(slot) < EP_SLOTS;
	assign nt_in_range = int'(slot) < NT_SLOTS;

	always_comb begin
		info = '0;
		// scan from the top so the lowest clear bit wins
		for (int i = EP_SLOTS - 1; i >= 0; i--) begin
			if (!ep_used_q[i]) begin
				info.ep_free_ok  = 1'b1;
				info.ep_free_idx = EP_IDX_W'(i);
			end
		end
		for (int i = NT_SLOTS - 1; i >= 0; i--) begin
			if (!nt_used_q[i]) begin
				info.nt_free_ok  = 1'b1;
				info.nt_free_idx = NT_IDX_W'(i);
			end
		end
		info.ep_used  = ep_in_range && ep_used_q[ep_sel];
		info.ep_owner = ep_owner_q[ep_sel];
		info.nt_used  = nt_in_range && nt_used_q[nt_sel];
		info.nt_owner = nt_owner_q[nt_sel];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ep_used_q  <= '0;
			ep_owner_q <= '0;
			nt_used_q  <= '0;
			nt_owner_q <= '0;
		end else if (commit) begin
			if (cmd.claim_ep) begin
				ep_used_q[info.ep_free_idx]  <= 1'b1;
				ep_owner_q[info.ep_free_idx] <= cmd.owner;
			end
			if (cmd.claim_nt) begin
				nt_used_q[info.nt_free_idx]  <= 1'b1;
				nt_owner_q[info.nt_free_idx] <= cmd.owner;
			end
			if (cmd.release_ep)
				ep_used_q[ep_sel] <= 1'b0;
			if (cmd.release_nt)
				nt_used_q[nt_sel] <= 1'b0;
		end
	end

endmodule

// File: rtl/core/rba_bump.sv
// Region state: watermarks, live object counts, aligned bump and headroom check,
// and the per-region statistics. Depends on rba_pkg.
module rba_bump
	import rba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SIZE_W-1:0] kernel_size,
	input  logic [SIZE_W-1:0] root_size,
	input  logic              region,
	input  logic [OBJ_W-1:0]  need,
	input  logic              stat_region,
	input  logic              commit,
	input  rba_bump_upd_t     upd,
	output logic              fit,
	output logic [SIZE_W-1:0] arena_offset,
	output rba_stats_t        stats
);

	localparam logic [SIZE_W:0] ALIGN_M1 = (SIZE_W+1)'(ALIGN_BYTES - 1);

	logic [SIZE_W-1:0] wm_q  [2];
	logic [SIZE_W-1:0] cnt_q [2];

	logic [SIZE_W-1:0] size_r;
	logic [SIZE_W-1:0] base_r;
	logic [SIZE_W:0]   start;
	logic [SIZE_W:0]   rem;
	logic [SIZE_W+1:0] left;     // bytes left after the object, MSB is the borrow
	logic [SIZE_W-1:0] wm_new;
	logic [SIZE_W-1:0] size_s;
	logic [SIZE_W-1:0] wm_s;
	logic [SIZE_W-1:0] cnt_nx [2];

	assign size_r = region ? root_size : kernel_size;
	assign base_r = region ? kernel_size : '0;

	// round up to the alignment in 33 bits so a top-of-space watermark cannot wrap
	assign start  = ({1'b0, wm_q[region]} + ALIGN_M1) & ~ALIGN_M1;
	assign rem    = {1'b0, size_r} - start;
	assign left   = {1'b0, rem} - (SIZE_W+2)'(need);
	assign fit    = (start < {1'b0, size_r}) && !left[SIZE_W+1];
	assign wm_new = SIZE_W'(start + (SIZE_W+1)'(need));
	assign arena_offset = base_r + start[SIZE_W-1:0];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			cnt_nx[i] = cnt_q[i];
			if (upd.alloc && (region == 1'(i)) && (cnt_q[i] != '1))
				cnt_nx[i] = cnt_q[i] + 1'b1;
			if (upd.release_obj && (upd.owner == 1'(i)) && (cnt_q[i] != '0))
				cnt_nx[i] = cnt_q[i] - 1'b1;
		end
	end

	assign size_s = stat_region ? root_size : kernel_size;
	assign wm_s   = wm_q[stat_region];

	always_comb begin
		stats.objects = cnt_nx[stat_region];
		if (upd.alloc) begin
			stats.watermark  = wm_new;
			stats.free_bytes = left[SIZE_W-1:0];
		end else begin
			stats.watermark  = wm_s;
			stats.free_bytes = (wm_s < size_s) ? (size_s - wm_s) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm_q[0]  <= '0;
			wm_q[1]  <= '0;
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
		end else if (commit) begin
			if (upd.alloc)
				wm_q[region] <= wm_new;
			cnt_q[0] <= cnt_nx[0];
			cnt_q[1] <= cnt_nx[1];
		end
	end

endmodule

// File: rtl/core/region_bump_allocator_with_slots.sv
// Region bump allocator with endpoint and notification slot tables.
// An accepted input beat passes through the input register, then the result
// register, to its result beat; throughput one beat per cycle while the result
// side does not stall, set by the combinational decide-and-commit path between the two registers.
// Reset clears all region state, slot tables and configuration at once; no
// clearing pass. Depends on rba_pkg, rba_slots, rba_bump.
module region_bump_allocator_with_slots
	import rba_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [SIZE_W-1:0]    cfg_wdata,

	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,   // [0] region, [6:1] slot, [7] zero
	input  logic [2:0]           s_axis_tuser,   // [0] action, [2:1] object_type

	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [31:0] arena_offset, [37:32] slot_index, [69:38] region_watermark,
	// [101:70] region_free, [133:102] region_objects, [135:134] zero
	output logic [135:0]         m_axis_tdata,
	output logic [STATUS_W-1:0]  m_axis_tuser    // [2:0] status
);

	logic [SIZE_W-1:0] kernel_size_q;
	logic [SIZE_W-1:0] root_size_q;
	logic [OBJ_W-1:0]  cnode_size_q;
	logic [OBJ_W-1:0]  ep_size_q;
	logic [OBJ_W-1:0]  nt_size_q;

	logic              valid_s1;
	logic              action_s1;
	logic              region_s1;
	logic [1:0]        type_s1;
	logic [SLOT_W-1:0] slot_s1;

	logic              m_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SIZE_W-1:0] offset_q;
	logic [SLOT_W-1:0] slot_q;
	rba_stats_t        stats_q;

	logic              advance;
	logic [OBJ_W-1:0]  need;
	rba_slot_info_t    sinfo;
	rba_slot_cmd_t     scmd;
	rba_bump_upd_t     bupd;
	logic              fit;
	logic [SIZE_W-1:0] offset_c;
	rba_stats_t        stats_c;
	logic              stat_region;
	logic [STATUS_W-1:0] status_c;
	logic [SLOT_W-1:0] slot_c;

	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_size_q <= '0;
			root_size_q   <= '0;
			cnode_size_q  <= '0;
			ep_size_q     <= '0;
			nt_size_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_KERNEL_SIZE: kernel_size_q <= cfg_wdata;
				REG_ROOT_SIZE:   root_size_q   <= cfg_wdata;
				REG_CNODE_SIZE:  cnode_size_q  <= cfg_wdata[OBJ_W-1:0];
				REG_EP_SIZE:     ep_size_q     <= cfg_wdata[OBJ_W-1:0];
				REG_NT_SIZE:     nt_size_q     <= cfg_wdata[OBJ_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			action_s1 <= s_axis_tuser[0];
			type_s1   <= s_axis_tuser[2:1];
			region_s1 <= s_axis_tdata[0];
			slot_s1   <= s_axis_tdata[6:1];
		end
	end

	always_comb begin
		case (type_s1)
			OBJ_CNODE: need = cnode_size_q;
			OBJ_EP:    need = ep_size_q;
			OBJ_NT:    need = nt_size_q;
			default:   need = '0;
		endcase
	end

	rba_slots u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.cmd    (scmd),
		.slot   (slot_s1),
		.info   (sinfo)
	);

	rba_bump u_bump (
		.clk          (clk),
		.arst_n       (arst_n),
		.kernel_size  (kernel_size_q),
		.root_size    (root_size_q),
		.region       (region_s1),
		.need         (need),
		.stat_region  (stat_region),
		.commit       (advance),
		.upd          (bupd),
		.fit          (fit),
		.arena_offset (offset_c),
		.stats        (stats_c)
	);

	// decide status and the state updates for the beat in the input register
	always_comb begin
		status_c    = ST_OK;
		slot_c      = '0;
		stat_region = region_s1;
		scmd        = '0;
		scmd.owner  = region_s1;
		bupd        = '0;
		if (action_s1 == ACT_DESTROY) begin
			slot_c = slot_s1;
			case (type_s1)
				OBJ_EP: begin
					if (!sinfo.ep_used) begin
						status_c = ST_EMPTY;
					end else begin
						stat_region      = sinfo.ep_owner;
						scmd.release_ep  = 1'b1;
						bupd.release_obj = 1'b1;
						bupd.owner       = sinfo.ep_owner;
					end
				end
				OBJ_NT: begin
					if (!sinfo.nt_used) begin
						status_c = ST_EMPTY;
					end else begin
						stat_region      = sinfo.nt_owner;
						scmd.release_nt  = 1'b1;
						bupd.release_obj = 1'b1;
						bupd.owner       = sinfo.nt_owner;
					end
				end
				default: status_c = ST_INVALID;
			endcase
		end else if (need == '0) begin
			status_c = ST_INVALID;
		end else if ((type_s1 == OBJ_EP && !sinfo.ep_free_ok) ||
		             (type_s1 == OBJ_NT && !sinfo.nt_free_ok)) begin
			status_c = ST_NO_SLOT;
		end else if (!fit) begin
			status_c = ST_FULL;
		end else begin
			bupd.alloc    = 1'b1;
			scmd.claim_ep = (type_s1 == OBJ_EP);
			scmd.claim_nt = (type_s1 == OBJ_NT);
			if (type_s1 == OBJ_EP)
				slot_c = SLOT_W'(sinfo.ep_free_idx);
			else if (type_s1 == OBJ_NT)
				slot_c = SLOT_W'(sinfo.nt_free_idx);
		end
	end

	// result register; holds while the master side stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (advance)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_c;
			offset_q <= bupd.alloc ? offset_c : '0;
			slot_q   <= slot_c;
			stats_q  <= stats_c;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {2'b00, stats_q.objects, stats_q.free_bytes,
	                        stats_q.watermark, slot_q, offset_q};

endmodule
